FILE: rtl/core/pida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_pkg
// Shared constants, codes and controller/datapath link types for the
// process identifier allocator.
// ----------------------------------------------------------------------------
package pida_pkg;

    localparam int POOL_SIZE_DEF = 8192;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = 6;
    localparam int ID_W          = 16;
    localparam int COUNT_W       = 14;

    localparam logic [ID_W-1:0]    BASE_ID_RST    = 16'd300;
    localparam logic [COUNT_W-1:0] POOL_COUNT_RST = 14'd4701;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic CFG_BASE_ID    = 1'b0;
    localparam logic CFG_POOL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_BAD_RELEASE = 2'd2
    } t_status;

    typedef struct packed {
        logic in_ready;
        logic clear_step;
        logic scan_next;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic accepted;
        logic clear_last;
        logic done;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/pida_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_req_if
// Request channel: one beat carries an allocate or release request.
// ----------------------------------------------------------------------------
interface pida_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] release_id;

    modport source (output valid, output action, output release_id, input ready);
    modport sink   (input valid, input action, input release_id, output ready);
endinterface

FILE: rtl/core/pida_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_rsp_if
// Response channel: one beat carries the granted identifier and a status.
// ----------------------------------------------------------------------------
interface pida_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] granted_id;
    logic [1:0]  status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface

FILE: rtl/core/pida_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_ctrl
// Sequencer for the allocator: clearing pass after reset, request intake,
// word-by-word bitmap scan and result commit.
// ----------------------------------------------------------------------------
module pida_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pida_pkg::t_stat i_stat,
    output pida_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.accepted) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.done) begin
                    if (i_stat.out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/pida_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_datapath
// In-use bitmap memory of 64-bit words, configuration registers, scan
// evaluation and the registered response stage.
// ----------------------------------------------------------------------------
module pida_datapath #(
    parameter int POOL_SIZE = pida_pkg::POOL_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    pida_req_if.sink            i_req,
    pida_rsp_if.source          o_rsp,
    input  pida_pkg::t_cmd      i_cmd,
    output pida_pkg::t_stat     o_stat
);

    localparam int WW    = pida_pkg::WORD_W;
    localparam int BW    = pida_pkg::BIT_W;
    localparam int IW    = pida_pkg::ID_W;
    localparam int CNTW  = pida_pkg::COUNT_W;
    localparam int WORDS = (POOL_SIZE + WW - 1) / WW;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W = WA_W + BW;
    localparam int EXT_W = $clog2(POOL_SIZE + 1);
    localparam int C_W   = (CNTW > EXT_W) ? CNTW : EXT_W;
    localparam int R_W   = (IW > EXT_W) ? IW : EXT_W;
    localparam int D_W   = ((EXT_W > IDX_W) ? EXT_W : IDX_W) + 1;

    logic [WW-1:0]   r_map [WORDS];
    logic [WW-1:0]   r_rd_data;
    logic [IW-1:0]   r_base;
    logic [CNTW-1:0] r_pool_cnt;
    logic            r_action;
    logic [WA_W-1:0] r_word;
    logic [BW-1:0]   r_bit;
    logic            r_in_range;
    logic [WA_W-1:0] r_clr;
    logic            r_out_valid;
    logic [IW-1:0]   r_out_id;
    logic [1:0]      r_out_status;

    logic [EXT_W-1:0] eff;
    logic [C_W-1:0]   cnt_ext;
    logic             accepted;
    logic [IW-1:0]    rel_idx;
    logic             rel_in_range;
    logic [WA_W-1:0]  rel_word;
    logic [WA_W-1:0]  n_word;
    logic             rd_en;
    logic [IDX_W-1:0] base_idx;
    logic [D_W-1:0]   rem;
    logic             scan_last;
    logic [WW-1:0]    mask;
    logic [WW-1:0]    free_vec;
    logic             found;
    logic [BW-1:0]    first;
    logic             hit;
    logic             wr_en;
    logic [WA_W-1:0]  wr_addr;
    logic [WW-1:0]    wr_data;
    logic [IW-1:0]    res_id;
    logic [1:0]       res_status;

    always_comb begin
        cnt_ext = C_W'(r_pool_cnt);
        if (cnt_ext > C_W'(POOL_SIZE)) begin
            eff = EXT_W'(POOL_SIZE);
        end else begin
            eff = EXT_W'(cnt_ext);
        end
    end

    assign i_req.ready  = i_cmd.in_ready;
    assign accepted     = i_req.valid && i_cmd.in_ready;
    assign rel_idx      = i_req.release_id - r_base;
    assign rel_in_range = R_W'(rel_idx) < R_W'(eff);
    assign rel_word     = rel_in_range ? rel_idx[BW +: WA_W] : '0;

    always_comb begin
        rd_en  = 1'b0;
        n_word = r_word;
        if (accepted) begin
            rd_en = 1'b1;
            if (i_req.action == pida_pkg::ACT_RELEASE) begin
                n_word = rel_word;
            end else begin
                n_word = '0;
            end
        end else if (i_cmd.scan_next) begin
            rd_en  = 1'b1;
            n_word = r_word + WA_W'(1);
        end
    end

    assign base_idx  = {r_word, {BW{1'b0}}};
    assign rem       = D_W'(eff) - D_W'(base_idx);
    assign scan_last = rem[D_W-1] || (rem <= D_W'(WW));

    always_comb begin
        if (rem[D_W-1]) begin
            mask = '0;
        end else if (rem >= D_W'(WW)) begin
            mask = '1;
        end else begin
            mask = (WW'(1) << rem[BW-1:0]) - WW'(1);
        end
    end

    assign free_vec = ~r_rd_data & mask;
    assign found    = |free_vec;

    always_comb begin
        first = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                first = BW'(b);
            end
        end
    end

    assign hit = r_in_range && r_rd_data[r_bit];

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_word;
        wr_data    = r_rd_data;
        res_id     = '0;
        res_status = pida_pkg::ST_OK;
        if (r_action == pida_pkg::ACT_ALLOC) begin
            wr_data = r_rd_data | (WW'(1) << first);
            if (found) begin
                res_id = r_base + IW'(base_idx) + IW'(first);
                wr_en  = i_cmd.commit;
            end else begin
                res_status = pida_pkg::ST_EXHAUSTED;
            end
        end else begin
            wr_data = r_rd_data & ~(WW'(1) << r_bit);
            if (hit) begin
                wr_en = i_cmd.commit;
            end else begin
                res_status = pida_pkg::ST_BAD_RELEASE;
            end
        end
        if (i_cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_map[n_word];
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (accepted) begin
            r_action   <= i_req.action;
            r_bit      <= rel_idx[BW-1:0];
            r_in_range <= rel_in_range;
        end
        if (i_cmd.commit) begin
            r_out_id     <= res_id;
            r_out_status <= res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= pida_pkg::BASE_ID_RST;
            r_pool_cnt  <= pida_pkg::POOL_COUNT_RST;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pida_pkg::CFG_BASE_ID:    r_base     <= i_cfg_data;
                    pida_pkg::CFG_POOL_COUNT: r_pool_cnt <= i_cfg_data[CNTW-1:0];
                    default:                  r_base     <= r_base;
                endcase
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + WA_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.granted_id = r_out_id;
    assign o_rsp.status     = r_out_status;

    always_comb begin
        o_stat            = '0;
        o_stat.accepted   = accepted;
        o_stat.clear_last = (r_clr == WA_W'(WORDS - 1));
        o_stat.done       = (r_action == pida_pkg::ACT_RELEASE) || found || scan_last;
        o_stat.out_free   = !r_out_valid || o_rsp.ready;
    end

endmodule

FILE: rtl/core/process_id_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_id_allocator_core
// Bitmap allocator that grants the lowest free process identifier of a pool
// and takes identifiers back on release.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (valid/ready); each beat is an allocate or a
// release. Every request yields exactly one beat on o_rsp with the granted
// identifier (zero unless an allocate succeeds) and a status code.
// base_id and pool_count must be written through i_cfg_we/i_cfg_idx/i_cfg_data
// only while no request is in flight; the core itself does not enforce this.
// The in-use map sits in a memory of 64-bit words. A release checks only the
// word that holds its identifier. An allocate scans one word per cycle from
// word zero up to the word holding the first free entry, so it reads at
// least one and at most ceil(min(pool_count, POOL_SIZE) / 64) words. Once
// the result is registered, the core returns to idle for the next request.
// After reset the core clears all ceil(POOL_SIZE / 64) words of the map
// (128 at the default size), one word per cycle, with i_req.ready low.
// The response sits in an output register; a new request is accepted while
// it waits, but that request's result holds until o_rsp has been drained.
// ----------------------------------------------------------------------------
module process_id_allocator_core #(
    parameter int POOL_SIZE = pida_pkg::POOL_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    pida_req_if.sink    i_req,
    pida_rsp_if.source  o_rsp
);

    pida_pkg::t_cmd  cmd;
    pida_pkg::t_stat stat;

    pida_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pida_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule
